/* design/cus11_pkg.sv */
package cus11_pkg;

    localparam int WORD_W      = 64;
    localparam int COEFF_WIDTH = 32;
    localparam int COEFF_PORT_W = 32;
    localparam int DIGIT_W     = 4;
    localparam int COUNT_W     = 6;
    localparam int CHUNK_W     = 16;
    localparam int NUM_CHUNKS  = (2 * WORD_W) / CHUNK_W;
    localparam int STEP_W      = CHUNK_W + DIGIT_W;

    localparam logic [WORD_W-1:0] LIMIT_HI = 64'hffd1390a0adc2fb8;
    localparam logic [WORD_W-1:0] LIMIT_LO = 64'hdabbb8174d95c99a;

    localparam logic [COUNT_W-1:0] DIGITS_PER_RUN = 6'd37;
    localparam logic [DIGIT_W-1:0] RADIX          = 4'd11;
    localparam logic [DIGIT_W-1:0] MAX_DIGIT      = 4'd10;
    localparam logic [DIGIT_W-1:0] CENTER_MAX     = 4'd5;

    localparam logic [COEFF_PORT_W-1:0] MODULUS_RESET = 32'd12289;
    localparam logic [COEFF_PORT_W-1:0] COEFF_MASK =
        COEFF_PORT_W'((64'd1 << COEFF_WIDTH) - 64'd1);

    // ceil(2^24 / 11); exact floor(v / 11) for every v below 11 * 2^16
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = STEP_W + RECIP_SHIFT - 3;
    localparam logic [PROD_W-1:0] RECIP11 = PROD_W'(((64'd1 << RECIP_SHIFT) + 64'd10) / 64'd11);

    typedef enum logic [1:0] {
        ST_HIGH,
        ST_LOW,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load_high;
        logic load_pair;
        logic issue;
        logic last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic word_hi_ok;
        logic pair_ok;
        logic busy;
        logic advance;
    } dp_status_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] quot;
        logic [DIGIT_W-1:0] rem;
    } div_step_t;

    // one radix-2^16 long-division step: (rem_in * 2^16 + chunk) / 11
    function automatic div_step_t div11_step(logic [DIGIT_W-1:0] rem_in,
                                             logic [CHUNK_W-1:0] chunk);
        logic [STEP_W-1:0] v;
        logic [PROD_W-1:0] prod;
        logic [CHUNK_W-1:0] q;
        logic [STEP_W-1:0] back;
        div_step_t res;
        v     = {rem_in, chunk};
        prod  = PROD_W'(v) * RECIP11;
        q     = prod[RECIP_SHIFT +: CHUNK_W];
        back  = v - STEP_W'(q) * STEP_W'(RADIX);
        res.quot = q;
        res.rem  = back[DIGIT_W-1:0];
        return res;
    endfunction

endpackage

/* design/cus11_ctrl.sv */
module cus11_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cus11_pkg::dp_status_t status,
    output cus11_pkg::ctrl_cmd_t  cmd
);
    import cus11_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    logic [COUNT_W-1:0]   digits_left_reg;
    logic [COUNT_W-1:0]   digits_left_next;
    logic                 in_fire;

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_HIGH;
            digits_left_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            digits_left_reg <= digits_left_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        digits_left_next = digits_left_reg;
        unique case (state_reg)
            ST_HIGH:
            begin
                if (in_fire && status.word_hi_ok)
                    state_next = ST_LOW;
            end
            ST_LOW:
            begin
                if (in_fire)
                begin
                    if (status.pair_ok)
                    begin
                        state_next       = ST_RUN;
                        digits_left_next = DIGITS_PER_RUN;
                    end
                    else
                        state_next = ST_HIGH;
                end
            end
            ST_RUN:
            begin
                if (status.advance)
                begin
                    digits_left_next = digits_left_reg - COUNT_W'(1);
                    if (digits_left_reg == COUNT_W'(1))
                        state_next = ST_HIGH;
                end
            end
            default:
            begin
                state_next       = ST_HIGH;
                digits_left_next = '0;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load_high = 1'b0;
        cmd.load_pair = 1'b0;
        cmd.issue     = 1'b0;
        cmd.last      = (digits_left_reg == COUNT_W'(1));
        unique case (state_reg)
            ST_HIGH:
            begin
                // next high half may arrive while the previous run drains
                in_ready      = 1'b1;
                cmd.load_high = in_valid && status.word_hi_ok;
            end
            ST_LOW:
            begin
                // the division array must be empty before a new pair loads
                in_ready      = !status.busy;
                cmd.load_pair = in_valid && !status.busy && status.pair_ok;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_run_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> digits_left_reg != '0)
        else $error("run state with no digits left");

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_RUN |-> digits_left_reg == '0)
        else $error("digit count nonzero outside a run");

    a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_pair |=> state_reg == ST_RUN && digits_left_reg == DIGITS_PER_RUN)
        else $error("pair load did not start a run");

endmodule

/* design/cus11_dp.sv */
module cus11_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [cus11_pkg::WORD_W-1:0]          rand_word,
    input  logic                                  cfg_valid,
    input  logic [cus11_pkg::COEFF_PORT_W-1:0]    cfg_data,
    input  cus11_pkg::ctrl_cmd_t                  cmd,
    output cus11_pkg::dp_status_t                 status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [cus11_pkg::DIGIT_W-1:0]         raw_digit,
    output logic [cus11_pkg::COEFF_PORT_W-1:0]    coefficient,
    output logic                                  last_digit
);
    import cus11_pkg::*;

    logic [COEFF_PORT_W-1:0] modulus_reg;
    logic [WORD_W-1:0]       high_half_reg;

    // skewed division array: stage j owns 16-bit chunk j (j = 0 is the top)
    logic [CHUNK_W-1:0]      chunk_reg [NUM_CHUNKS];
    logic [DIGIT_W-1:0]      rem_reg   [NUM_CHUNKS];
    logic [NUM_CHUNKS-1:0]   act_reg;
    logic [NUM_CHUNKS-1:0]   last_reg;

    logic [NUM_CHUNKS-1:0]   stage_in_valid;
    logic [NUM_CHUNKS-1:0]   stage_in_last;
    logic [DIGIT_W-1:0]      stage_rem_in [NUM_CHUNKS];
    div_step_t               stage_res    [NUM_CHUNKS];

    logic                    out_valid_reg;
    logic [DIGIT_W-1:0]      raw_reg;
    logic [COEFF_PORT_W-1:0] coef_reg;
    logic                    last_out_reg;

    logic                    advance;
    logic [DIGIT_W-1:0]      tail_digit;
    logic [COEFF_PORT_W-1:0] coef_wrapped;
    logic [COEFF_PORT_W-1:0] coef_value;
    logic [2*WORD_W-1:0]     pair_value;

    assign advance    = !out_valid_reg || out_ready;
    assign pair_value = {high_half_reg, rand_word};

    assign status.word_hi_ok = (rand_word <= LIMIT_HI);
    assign status.pair_ok    = !((high_half_reg == LIMIT_HI) && (rand_word > LIMIT_LO));
    assign status.busy       = |act_reg;
    assign status.advance    = advance;

    always_comb
    begin
        for (int j = 0; j < NUM_CHUNKS; j++)
        begin
            if (j == 0)
            begin
                stage_in_valid[j] = cmd.issue;
                stage_in_last[j]  = cmd.last;
                stage_rem_in[j]   = '0;
            end
            else
            begin
                stage_in_valid[j] = act_reg[j-1];
                stage_in_last[j]  = last_reg[j-1];
                stage_rem_in[j]   = rem_reg[j-1];
            end
            stage_res[j] = div11_step(stage_rem_in[j], chunk_reg[j]);
        end
    end

    assign tail_digit   = rem_reg[NUM_CHUNKS-1];
    assign coef_wrapped = COEFF_PORT_W'(tail_digit) + modulus_reg - COEFF_PORT_W'(RADIX);
    assign coef_value   = ((tail_digit <= CENTER_MAX) ? COEFF_PORT_W'(tail_digit)
                                                      : coef_wrapped) & COEFF_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MODULUS_RESET;
            act_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                modulus_reg <= cfg_data;
            if (advance)
            begin
                act_reg       <= stage_in_valid;
                last_reg      <= stage_in_last & stage_in_valid;
                out_valid_reg <= act_reg[NUM_CHUNKS-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_high)
            high_half_reg <= rand_word;
        for (int j = 0; j < NUM_CHUNKS; j++)
        begin
            if (cmd.load_pair)
                chunk_reg[j] <= pair_value[(NUM_CHUNKS-1-j)*CHUNK_W +: CHUNK_W];
            else if (advance && stage_in_valid[j])
            begin
                chunk_reg[j] <= stage_res[j].quot;
                rem_reg[j]   <= stage_res[j].rem;
            end
        end
        if (advance)
        begin
            raw_reg      <= tail_digit;
            coef_reg     <= coef_value;
            last_out_reg <= last_reg[NUM_CHUNKS-1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign raw_digit   = raw_reg;
    assign coefficient = coef_reg;
    assign last_digit  = last_out_reg;

    a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_pair |-> !status.busy)
        else $error("pair loaded while the division array is busy");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> raw_reg <= MAX_DIGIT)
        else $error("digit out of range");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(last_reg & act_reg) <= 1)
        else $error("more than one run end in flight");

endmodule

/* design/centered_uniform_sampler_mod11_core.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    rand_word[63:0]
// out       output     out_valid / out_ready  raw_digit[3:0], coefficient[31:0], last_digit
// cfg       input      cfg_valid / cfg_ready  cfg_data[31:0] (prime_modulus)
//
// An accepted pair loads an 8-stage skewed radix-2^16 divide-by-11 array and issues
// one digit per cycle while out is not stalled, 37 digits in all; the first digit
// passes every stage register and then the output register before it shows on out.
// A low half waits until the array has drained; a high half is taken meanwhile.
// A stall on out freezes the whole array. Reset clears control and sets q to 12289.
module centered_uniform_sampler_mod11_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [cus11_pkg::WORD_W-1:0]          rand_word,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [cus11_pkg::DIGIT_W-1:0]         raw_digit,
    output logic [cus11_pkg::COEFF_PORT_W-1:0]    coefficient,
    output logic                                  last_digit,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cus11_pkg::COEFF_PORT_W-1:0]    cfg_data
);
    import cus11_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    cus11_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cus11_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rand_word   (rand_word),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .raw_digit   (raw_digit),
        .coefficient (coefficient),
        .last_digit  (last_digit)
    );

endmodule
